FILE: hdl/assert_macros.svh
// Assertion macros shared by the time-varied gain RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check with active-low reset disable.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    `ASSERT_AT(label, clk, rstn, !(expr), msg)

`endif

FILE: hdl/tvg_pkg.sv
// Shared types, constants and the 2^(2^-k) table for the time-varied gain block.
// No dependencies; used by every module of the block.
package tvg_pkg;

    localparam int LOG_TABLE_BITS_DEF  = 10;
    localparam int RANGE_FRAC_BITS_DEF = 8;

    localparam int AMP_W     = 16;
    localparam int RNG_W     = 18;
    localparam int CFG_W     = 14;
    localparam int E_W       = 5;
    localparam int Q30_W     = 31;
    localparam int DIV_STEPS = 30;
    localparam int GAIN_W    = 23;
    localparam int SPT_W     = 26;
    localparam int ABS_W     = 32;
    localparam int N_W       = 5;
    localparam int N_MAX     = 20;
    localparam int CNT_W     = 5;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [CFG_W-1:0]  SPREAD_MAX     = 14'd10240;
    localparam logic [CFG_W-1:0]  ABSORB_MAX     = 14'd8192;
    localparam int                FALLBACK_MAX_M = 50;
    localparam logic [CFG_W-1:0]  FALLBACK_RST   = 14'd256;
    localparam logic [GAIN_W-1:0] GAIN_MAX_Q16   = 23'(97 << 16);
    localparam logic [Q30_W-1:0]  ONE_Q30        = 31'h4000_0000;
    localparam logic [28:0]       LOG10_2_Q30    = 29'd323228497;
    localparam logic [27:0]       LOG2_10_D20    = 28'd178344152;
    localparam logic [AMP_W-1:0]  AMP_MAX        = 16'hFFFF;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_SPREAD   = 2'd1;
    localparam logic [1:0] REG_ABSORB   = 2'd2;
    localparam logic [1:0] REG_FALLBACK = 2'd3;

    typedef struct packed {
        logic [AMP_W-1:0] amplitude;
        logic [RNG_W-1:0] range_q8;
        logic [RNG_W-1:0] blanking_q8;
        logic             blanking_valid;
        logic [RNG_W-1:0] slant_range_q8;
        logic             ping_unusable;
        logic             last_of_ping;
    } tvg_in_t;

    typedef struct packed {
        logic [AMP_W-1:0] corrected_amplitude;
        logic             ping_applied;
        logic             end_of_ping;
    } tvg_out_t;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] spreading;
        logic [CFG_W-1:0] absorption;
        logic [CFG_W-1:0] fallback;
    } tvg_cfg_t;

    typedef struct packed {
        logic [AMP_W-1:0] amp;
        logic             last;
        logic             bypass;
        logic [E_W-1:0]   e;
        logic [RNG_W-1:0] dvsr;
        logic [RNG_W-1:0] rem;
        logic [RNG_W-1:0] diff;
    } tvg_entry_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_LOG,
        BK_MUL,
        BK_TERM,
        BK_SUM,
        BK_SCALE,
        BK_EXP,
        BK_APPLY,
        BK_SAT,
        BK_DONE
    } tvg_state_t;

    // 2^(2^-(idx+1)) in Q30
    function automatic logic [Q30_W-1:0] exp2_frac(input logic [3:0] idx);
        logic [Q30_W-1:0] v;
        unique case (idx)
            4'd0:    v = 31'd1518500250;
            4'd1:    v = 31'd1276901417;
            4'd2:    v = 31'd1170923762;
            4'd3:    v = 31'd1121280436;
            4'd4:    v = 31'd1097253708;
            4'd5:    v = 31'd1085434106;
            4'd6:    v = 31'd1079572136;
            4'd7:    v = 31'd1076653033;
            4'd8:    v = 31'd1075196443;
            4'd9:    v = 31'd1074468888;
            4'd10:   v = 31'd1074105294;
            4'd11:   v = 31'd1073923544;
            4'd12:   v = 31'd1073832680;
            4'd13:   v = 31'd1073787251;
            default: v = ONE_Q30;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/sonar_time_varied_gain.sv
// Top level of the sidescan time-varied gain block.
// Depends on tvg_pkg, tvg_cfg, tvg_front, tvg_fifo and tvg_back.
//
// channel   dir  handshake               payload
// s_*       in   s_valid / s_ready       tvg_pkg::tvg_in_t
// m_*       out  m_valid / m_ready       tvg_pkg::tvg_out_t
// apb       in   psel, penable / pready  paddr[3:0], pwdata / prdata 32 bit
//
// A pass-through sample skips the gain states; a gained sample's time is
// set by the one-bit-per-cycle divider for the log2 mantissa and the
// serial squaring and 2^x multiply loops in tvg_back.
// Reset: synchronous, active low, clears control only; no clearing pass.
// A two-beat queue lets input keep flowing while the engine works, and the
// output register holds one finished beat while the engine starts the next.
module sonar_time_varied_gain #(
    parameter int LOG_TABLE_BITS  = tvg_pkg::LOG_TABLE_BITS_DEF,
    parameter int RANGE_FRAC_BITS = tvg_pkg::RANGE_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  tvg_pkg::tvg_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tvg_pkg::tvg_out_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tvg_pkg::ADDR_W-1:0] paddr,
    input  logic [tvg_pkg::DATA_W-1:0] pwdata,
    output logic [tvg_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    tvg_pkg::tvg_cfg_t   cfg;
    tvg_pkg::tvg_entry_t push_entry;
    tvg_pkg::tvg_entry_t pop_entry;
    logic                q_push;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;

    tvg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tvg_front #(
        .RANGE_FRAC_BITS (RANGE_FRAC_BITS)
    ) u_front (
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    tvg_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (push_entry),
        .full     (q_full),
        .rd_valid (q_valid),
        .pop      (q_pop),
        .rd_entry (pop_entry)
    );

    tvg_back #(
        .LOG_TABLE_BITS  (LOG_TABLE_BITS),
        .RANGE_FRAC_BITS (RANGE_FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_entry (pop_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: hdl/tvg_cfg.sv
// APB register file for the time-varied gain block, with clamped spreading and absorption outputs.
// Depends on tvg_pkg.
module tvg_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tvg_pkg::ADDR_W-1:0] paddr,
    input  logic [tvg_pkg::DATA_W-1:0] pwdata,
    output logic [tvg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tvg_pkg::tvg_cfg_t          cfg
);

    logic                      enable_reg;
    logic [tvg_pkg::CFG_W-1:0] spread_reg;
    logic [tvg_pkg::CFG_W-1:0] absorb_reg;
    logic [tvg_pkg::CFG_W-1:0] fallback_reg;
    logic [1:0]                idx;
    logic                      wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            spread_reg   <= '0;
            absorb_reg   <= '0;
            fallback_reg <= tvg_pkg::FALLBACK_RST;
        end else if (wr_en) begin
            unique case (idx)
                tvg_pkg::REG_ENABLE:   enable_reg   <= pwdata[0];
                tvg_pkg::REG_SPREAD:   spread_reg   <= pwdata[tvg_pkg::CFG_W-1:0];
                tvg_pkg::REG_ABSORB:   absorb_reg   <= pwdata[tvg_pkg::CFG_W-1:0];
                tvg_pkg::REG_FALLBACK: fallback_reg <= pwdata[tvg_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tvg_pkg::REG_ENABLE:   prdata = {31'd0, enable_reg};
            tvg_pkg::REG_SPREAD:   prdata = {18'd0, spread_reg};
            tvg_pkg::REG_ABSORB:   prdata = {18'd0, absorb_reg};
            tvg_pkg::REG_FALLBACK: prdata = {18'd0, fallback_reg};
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        cfg.enable     = enable_reg;
        cfg.spreading  = (spread_reg > tvg_pkg::SPREAD_MAX) ? tvg_pkg::SPREAD_MAX : spread_reg;
        cfg.absorption = (absorb_reg > tvg_pkg::ABSORB_MAX) ? tvg_pkg::ABSORB_MAX : absorb_reg;
        cfg.fallback   = fallback_reg;
    end

endmodule

FILE: hdl/tvg_front.sv
// Front end: accepts samples, resolves the reference range and classifies
// each one as pass-through or gain; prepares the log2 divider operands. Depends on tvg_pkg.
module tvg_front #(
    parameter int RANGE_FRAC_BITS = tvg_pkg::RANGE_FRAC_BITS_DEF
) (
    input  tvg_pkg::tvg_cfg_t   cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  tvg_pkg::tvg_in_t    s_data,
    input  logic                q_full,
    output logic                q_push,
    output tvg_pkg::tvg_entry_t q_entry
);

    localparam int RW = tvg_pkg::RNG_W;

    logic [RW-1:0]                fb_max;
    logic [RW-1:0]                fb;
    logic [RW-1:0]                blank;
    logic [RW-1:0]                one_m;
    logic [RW-1:0]                ref_dist;
    logic [RW-1:0]                dvsr;
    logic [RW-2:0]                ge;
    logic [tvg_pkg::E_W-1:0]      e;
    logic                         gain_on;

    always_comb begin
        fb_max  = RW'(tvg_pkg::FALLBACK_MAX_M) << RANGE_FRAC_BITS;
        fb      = (RW'(cfg.fallback) > fb_max) ? fb_max : RW'(cfg.fallback);
        blank   = s_data.blanking_valid ? s_data.blanking_q8 : fb;
        one_m   = RW'(1) << RANGE_FRAC_BITS;
        ref_dist = (blank > one_m) ? blank : one_m;
        for (int k = 1; k < RW; k++) begin
            ge[k-1] = (({{RW{1'b0}}, ref_dist} << k) <= {{RW{1'b0}}, s_data.range_q8});
        end
        e       = tvg_pkg::E_W'($countones(ge));
        dvsr    = ref_dist << e;
        gain_on = cfg.enable && !s_data.ping_unusable && (s_data.slant_range_q8 != '0)
                  && (s_data.slant_range_q8 > blank) && (s_data.range_q8 > ref_dist);

        q_entry.amp    = s_data.amplitude;
        q_entry.last   = s_data.last_of_ping;
        q_entry.bypass = !gain_on;
        q_entry.e      = e;
        q_entry.dvsr   = dvsr;
        q_entry.rem    = s_data.range_q8 - dvsr;
        q_entry.diff   = s_data.range_q8 - ref_dist;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

FILE: hdl/tvg_fifo.sv
// Two-entry queue between the front end and the gain engine.
// Depends on tvg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tvg_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tvg_pkg::tvg_entry_t wr_entry,
    output logic                full,
    output logic                rd_valid,
    input  logic                pop,
    output tvg_pkg::tvg_entry_t rd_entry
);

    tvg_pkg::tvg_entry_t              mem_reg [tvg_pkg::QDEPTH];
    logic [tvg_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [tvg_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [tvg_pkg::QCNT_W-1:0]       count_reg;

    assign full     = (count_reg == tvg_pkg::QCNT_W'(tvg_pkg::QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_push_full, aclk, aresetn, push && full && !pop, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && !rd_valid, "pop from empty queue")

endmodule

FILE: hdl/tvg_back.sv
// Gain engine: bit-serial divide for the log2 mantissa, serial squaring for
// log2, gain sum, serial 2^x product, amplitude scale and output register.
// Depends on tvg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tvg_back #(
    parameter int LOG_TABLE_BITS  = tvg_pkg::LOG_TABLE_BITS_DEF,
    parameter int RANGE_FRAC_BITS = tvg_pkg::RANGE_FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tvg_pkg::tvg_cfg_t   cfg,
    input  logic                q_valid,
    input  tvg_pkg::tvg_entry_t q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output tvg_pkg::tvg_out_t   m_data
);

    localparam int LTB  = LOG_TABLE_BITS;
    localparam int RW   = tvg_pkg::RNG_W;
    localparam int QW   = tvg_pkg::Q30_W;
    localparam int LW   = tvg_pkg::E_W + LTB;
    localparam int PSW  = tvg_pkg::CFG_W + LW;
    localparam int SFW  = PSW + 29;
    localparam int PAW  = tvg_pkg::CFG_W + RW;
    localparam int PFW  = tvg_pkg::GAIN_W + 28;
    localparam int APW  = tvg_pkg::AMP_W + QW;
    localparam int VW   = APW + 21;

    tvg_pkg::tvg_state_t           state_reg, state_next;
    logic [tvg_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          m_valid_reg;
    logic                          pc_reg;
    tvg_pkg::tvg_out_t             m_data_reg;

    logic [tvg_pkg::AMP_W-1:0]     amp_reg;
    logic                          last_reg;
    logic [tvg_pkg::E_W-1:0]       e_reg;
    logic [RW-1:0]                 d_reg;
    logic [RW-1:0]                 rem_reg;
    logic [RW-1:0]                 diff_reg;
    logic [QW-1:0]                 q_reg;
    logic [LTB-1:0]                frac_reg;
    logic [PSW-1:0]                prod_s_reg;
    logic [PAW-1:0]                prod_a_reg;
    logic [tvg_pkg::SPT_W-1:0]     spread_term_reg;
    logic [tvg_pkg::ABS_W-1:0]     abs_term_reg;
    logic [tvg_pkg::GAIN_W-1:0]    g_reg;
    logic [tvg_pkg::N_W-1:0]       n_reg;
    logic [LTB-1:0]                pf_reg;
    logic [QW-1:0]                 factor_reg;
    logic [APW-1:0]                amp_prod_reg;
    logic [tvg_pkg::AMP_W-1:0]     res_reg;

    logic                          div_last;
    logic                          ser_last;
    logic                          out_load;
    logic                          changed;
    logic [RW:0]                   div_t;
    logic [2*QW-1:0]               sq;
    logic [31:0]                   sq_s;
    logic [SFW-1:0]                spread_full;
    logic [tvg_pkg::ABS_W:0]       g_sum;
    logic [PFW-1:0]                p_full;
    logic [2*QW-1:0]               fp;
    logic [VW-1:0]                 vw;
    logic                          sat;

    assign div_last = (cnt_reg == tvg_pkg::CNT_W'(tvg_pkg::DIV_STEPS - 1));
    assign ser_last = (cnt_reg == tvg_pkg::CNT_W'(LTB - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tvg_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = q_entry.bypass ? tvg_pkg::BK_DONE : tvg_pkg::BK_DIV;
                end
            end
            tvg_pkg::BK_DIV:   if (div_last) state_next = tvg_pkg::BK_LOG;
            tvg_pkg::BK_LOG:   if (ser_last) state_next = tvg_pkg::BK_MUL;
            tvg_pkg::BK_MUL:   state_next = tvg_pkg::BK_TERM;
            tvg_pkg::BK_TERM:  state_next = tvg_pkg::BK_SUM;
            tvg_pkg::BK_SUM:   state_next = tvg_pkg::BK_SCALE;
            tvg_pkg::BK_SCALE: state_next = tvg_pkg::BK_EXP;
            tvg_pkg::BK_EXP:   if (ser_last) state_next = tvg_pkg::BK_APPLY;
            tvg_pkg::BK_APPLY: state_next = tvg_pkg::BK_SAT;
            tvg_pkg::BK_SAT:   state_next = tvg_pkg::BK_DONE;
            tvg_pkg::BK_DONE:  if (!m_valid_reg || m_ready) state_next = tvg_pkg::BK_IDLE;
            default:           state_next = tvg_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        cnt_next = '0;
        unique case (state_reg)
            tvg_pkg::BK_IDLE: q_pop = q_valid;
            tvg_pkg::BK_DIV:  cnt_next = div_last ? '0 : cnt_reg + 1'b1;
            tvg_pkg::BK_LOG:  cnt_next = ser_last ? '0 : cnt_reg + 1'b1;
            tvg_pkg::BK_EXP:  cnt_next = ser_last ? '0 : cnt_reg + 1'b1;
            tvg_pkg::BK_DONE: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_comb begin
        div_t       = {rem_reg, 1'b0};
        sq          = (2*QW)'(q_reg) * (2*QW)'(q_reg);
        sq_s        = sq[61:30];
        spread_full = SFW'(prod_s_reg) * SFW'(tvg_pkg::LOG10_2_Q30);
        g_sum       = (tvg_pkg::ABS_W + 1)'(spread_term_reg)
                      + (tvg_pkg::ABS_W + 1)'(abs_term_reg);
        p_full      = PFW'(g_reg) * PFW'(tvg_pkg::LOG2_10_D20);
        fp          = (2*QW)'(factor_reg) * (2*QW)'(tvg_pkg::exp2_frac(cnt_reg[3:0]));
        vw          = (VW'(amp_prod_reg) << n_reg) >> 30;
        sat         = (n_reg > tvg_pkg::N_W'(tvg_pkg::N_MAX)) || (|vw[VW-1:tvg_pkg::AMP_W]);
        changed     = (res_reg != amp_reg);
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            tvg_pkg::BK_IDLE: begin
                amp_reg  <= q_entry.amp;
                res_reg  <= q_entry.amp;
                last_reg <= q_entry.last;
                e_reg    <= q_entry.e;
                d_reg    <= q_entry.dvsr;
                rem_reg  <= q_entry.rem;
                diff_reg <= q_entry.diff;
                q_reg    <= QW'(1);
            end
            tvg_pkg::BK_DIV: begin
                if (div_t >= {1'b0, d_reg}) begin
                    rem_reg <= RW'(div_t - {1'b0, d_reg});
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end else begin
                    rem_reg <= div_t[RW-1:0];
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
            end
            tvg_pkg::BK_LOG: begin
                if (sq_s[31]) begin
                    q_reg <= sq_s[31:1];
                end else begin
                    q_reg <= sq_s[30:0];
                end
                frac_reg <= {frac_reg[LTB-2:0], sq_s[31]};
            end
            tvg_pkg::BK_MUL: begin
                prod_s_reg <= PSW'(cfg.spreading) * PSW'({e_reg, frac_reg});
                prod_a_reg <= PAW'(cfg.absorption) * PAW'(diff_reg);
            end
            tvg_pkg::BK_TERM: begin
                spread_term_reg <= spread_full[LTB+22 +: tvg_pkg::SPT_W];
                abs_term_reg    <= tvg_pkg::ABS_W'(prod_a_reg >> (RANGE_FRAC_BITS - 4));
            end
            tvg_pkg::BK_SUM: begin
                g_reg <= (g_sum > (tvg_pkg::ABS_W + 1)'(tvg_pkg::GAIN_MAX_Q16))
                         ? tvg_pkg::GAIN_MAX_Q16 : g_sum[tvg_pkg::GAIN_W-1:0];
            end
            tvg_pkg::BK_SCALE: begin
                n_reg      <= p_full[PFW-1:46];
                pf_reg     <= p_full[46-LTB +: LTB];
                factor_reg <= tvg_pkg::ONE_Q30;
            end
            tvg_pkg::BK_EXP: begin
                if (pf_reg[LTB-1]) begin
                    factor_reg <= fp[60:30];
                end
                pf_reg <= {pf_reg[LTB-2:0], 1'b0};
            end
            tvg_pkg::BK_APPLY: begin
                amp_prod_reg <= APW'(amp_reg) * APW'(factor_reg);
            end
            tvg_pkg::BK_SAT: begin
                res_reg <= sat ? tvg_pkg::AMP_MAX : vw[tvg_pkg::AMP_W-1:0];
            end
            tvg_pkg::BK_DONE: begin
                if (out_load) begin
                    m_data_reg.corrected_amplitude <= res_reg;
                    m_data_reg.ping_applied        <= last_reg && (pc_reg || changed);
                    m_data_reg.end_of_ping         <= last_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tvg_pkg::BK_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            pc_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= !last_reg && (pc_reg || changed);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_AT(a_div_rem, aclk, aresetn, (state_reg == tvg_pkg::BK_DIV) |-> (rem_reg < d_reg), "divider remainder not below divisor")
    `ASSERT_AT(a_log_norm, aclk, aresetn, (state_reg == tvg_pkg::BK_LOG) |-> q_reg[QW-1], "log mantissa not normalized")
    `ASSERT_AT(a_applied_end, aclk, aresetn, m_valid_reg |-> (!m_data_reg.ping_applied || m_data_reg.end_of_ping), "ping_applied off the last beat")

endmodule
